### sv/fabs_pkg.sv
// Shared types, widths and helpers for the four-axis Bresenham stepper.
// No dependencies; imported by fabs_axis, four_axis_bresenham_stepper and the testbench.
package fabs_pkg;

  localparam int STEP_BITS = 24;
  localparam int POS_BITS  = 32;
  localparam int NUM_AXES  = 4;
  localparam int VAL_BITS  = 32;

  // signed difference of a value and a position, one bit of headroom
  localparam int DIFF_BITS = ((POS_BITS > VAL_BITS) ? POS_BITS : VAL_BITS) + 1;
  // error term: range [-L/2, L/2) plus the added delta, with margin
  localparam int ERR_BITS  = STEP_BITS + 3;

  localparam int IN_FIELD_BITS  = NUM_AXES + NUM_AXES * VAL_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * NUM_AXES + 2 + NUM_AXES * VAL_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef logic [STEP_BITS-1:0]       step_t;
  typedef logic [POS_BITS-1:0]        pos_t;
  typedef logic signed [ERR_BITS-1:0] err_t;
  typedef logic [VAL_BITS-1:0]        val_t;

  typedef enum logic {
    REQ_MOVE = 1'b0,
    REQ_TICK = 1'b1
  } req_e;

  // shared control from the top level to every axis
  typedef struct packed {
    logic  load;      // move beat: latch new delta and direction
    logic  run;       // tick beat with steps remaining
    logic  abs_mode;  // values are absolute targets
    step_t longest;   // latched longest delta
  } axis_ctrl_t;

  // sign-extend or cut a position to the width of an output field
  function automatic val_t pos_to_field(pos_t p);
    logic [POS_BITS+VAL_BITS-1:0] wide;
    wide = {{VAL_BITS{p[POS_BITS-1]}}, p};
    return wide[VAL_BITS-1:0];
  endfunction

endpackage

### sv/fabs_axis.sv
// One axis of the stepper: delta magnitude, error term, direction and position.
// Depends on fabs_pkg.
module fabs_axis (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  fabs_pkg::axis_ctrl_t ctrl_i,
  input  logic                 given_i,
  input  fabs_pkg::val_t       value_i,
  output fabs_pkg::step_t      mag_o,
  output logic                 step_o,
  output logic                 dir_o,
  output fabs_pkg::pos_t       pos_o
);
  import fabs_pkg::*;

  step_t delta_q, delta_d;
  err_t  err_q, err_d;
  logic  dir_q, dir_d;
  pos_t  pos_q, pos_d;

  logic signed [DIFF_BITS-1:0] val_x, pos_x, diff;
  logic [DIFF_BITS-1:0]        mag_full;
  step_t                       mag;
  logic                        dir_new;
  err_t                        sum;
  logic signed [ERR_BITS:0]    twice, lng_x;
  logic                        fire;

  // signed distance for a move and its saturated magnitude
  always_comb begin
    val_x = DIFF_BITS'($signed(value_i));
    pos_x = DIFF_BITS'($signed(pos_q));
    if (!given_i) begin
      diff = '0;
    end else if (ctrl_i.abs_mode) begin
      diff = val_x - pos_x;
    end else begin
      diff = val_x;
    end
    mag_full = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
    if (mag_full[DIFF_BITS-1:STEP_BITS] != '0) begin
      mag = '1;
    end else begin
      mag = mag_full[STEP_BITS-1:0];
    end
    dir_new = !diff[DIFF_BITS-1] && (diff != '0);
  end

  // advance the error term: step when twice the error reaches the longest delta
  always_comb begin
    sum   = err_q + $signed({{(ERR_BITS-STEP_BITS){1'b0}}, delta_q});
    twice = {sum, 1'b0};
    lng_x = $signed({{(ERR_BITS+1-STEP_BITS){1'b0}}, ctrl_i.longest});
    fire  = ctrl_i.run && (twice >= lng_x);
  end

  // next state
  always_comb begin
    delta_d = delta_q;
    err_d   = err_q;
    dir_d   = dir_q;
    pos_d   = pos_q;
    if (ctrl_i.load) begin
      delta_d = mag;
      err_d   = '0;
      dir_d   = dir_new;
    end else if (ctrl_i.run) begin
      if (fire) begin
        err_d = sum - $signed({{(ERR_BITS-STEP_BITS){1'b0}}, ctrl_i.longest});
        pos_d = dir_q ? pos_q + POS_BITS'(1) : pos_q - POS_BITS'(1);
      end else begin
        err_d = sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q <= '0;
      err_q   <= '0;
      dir_q   <= 1'b0;
      pos_q   <= '0;
    end else if (en_i) begin
      delta_q <= delta_d;
      err_q   <= err_d;
      dir_q   <= dir_d;
      pos_q   <= pos_d;
    end
  end

  assign mag_o  = mag;
  assign step_o = fire;
  assign dir_o  = dir_d;
  assign pos_o  = pos_d;

endmodule

### sv/four_axis_bresenham_stepper.sv
// Four-axis Bresenham step generator: moves latch per-axis deltas, ticks step.
// A beat accepted into the item register gives its result beat from the result register.
// One beat per cycle unless results stall; all four axes update in parallel in one pass.
// Backpressure on the result side stalls the single item register, nothing is lost.
// Reset clears deltas, errors, step count, directions and positions; absolute mode is 1.
// Depends on fabs_pkg and fabs_axis.
module four_axis_bresenham_stepper (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,     // abs mode: 1 = targets
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // axis_given[3:0], value_x, value_y, value_a, value_z (32 bits each), zero pad
  input  logic [fabs_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
  input  logic                                s_axis_tuser,    // req_type
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // steps[3:0], dirs[7:4], move_done[8], busy_res[9], pos_x, pos_y,
  // pos_a, pos_z (32 bits each), zero pad
  output logic [fabs_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);
  import fabs_pkg::*;

  logic                abs_mode_q;
  logic                in_valid_q;
  logic                in_type_q;
  logic [NUM_AXES-1:0] in_given_q;
  val_t                in_value_q [NUM_AXES];
  logic                adv;

  step_t               longest_q, longest_d;
  step_t               steps_left_q, steps_left_d;
  axis_ctrl_t          ctrl;
  logic                is_move;

  step_t               mag      [NUM_AXES];
  pos_t                pos_next [NUM_AXES];
  logic [NUM_AXES-1:0] step_next, dir_next;
  step_t               longest_new;
  logic                done_next, busy_next;

  logic                out_valid_q;
  logic [NUM_AXES-1:0] out_step_q, out_dir_q;
  logic                out_done_q, out_busy_q;
  val_t                out_pos_q [NUM_AXES];

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      abs_mode_q <= cfg_wdata_i;
    end
  end

  // item register: move on when the result register is free
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_type_q  <= s_axis_tuser;
      in_given_q <= s_axis_tdata[NUM_AXES-1:0];
      for (int i = 0; i < NUM_AXES; i++) begin
        in_value_q[i] <= s_axis_tdata[NUM_AXES + i*VAL_BITS +: VAL_BITS];
      end
    end
  end

  // shared control for the axes
  always_comb begin
    is_move       = (in_type_q == REQ_MOVE);
    ctrl.load     = is_move;
    ctrl.run      = !is_move && (steps_left_q != '0);
    ctrl.abs_mode = abs_mode_q;
    ctrl.longest  = longest_q;
  end

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
    fabs_axis u_axis (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .ctrl_i  (ctrl),
      .given_i (in_given_q[g]),
      .value_i (in_value_q[g]),
      .mag_o   (mag[g]),
      .step_o  (step_next[g]),
      .dir_o   (dir_next[g]),
      .pos_o   (pos_next[g])
    );
  end

  // longest delta of a move and the step count
  always_comb begin
    longest_new = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      if (mag[i] > longest_new) begin
        longest_new = mag[i];
      end
    end
    longest_d    = longest_q;
    steps_left_d = steps_left_q;
    if (ctrl.load) begin
      longest_d    = longest_new;
      steps_left_d = longest_new;
    end else if (ctrl.run) begin
      steps_left_d = steps_left_q - STEP_BITS'(1);
    end
    done_next = ctrl.run && (steps_left_q == STEP_BITS'(1));
    busy_next = (steps_left_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      longest_q    <= '0;
      steps_left_q <= '0;
    end else if (adv) begin
      longest_q    <= longest_d;
      steps_left_q <= steps_left_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_step_q <= step_next;
      out_dir_q  <= dir_next;
      out_done_q <= done_next;
      out_busy_q <= busy_next;
      for (int i = 0; i < NUM_AXES; i++) begin
        out_pos_q[i] <= pos_to_field(pos_next[i]);
      end
    end
  end

  // pack the result beat
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[NUM_AXES-1:0]          = out_step_q;
    m_axis_tdata[2*NUM_AXES-1:NUM_AXES] = out_dir_q;
    m_axis_tdata[2*NUM_AXES]            = out_done_q;
    m_axis_tdata[2*NUM_AXES+1]          = out_busy_q;
    for (int i = 0; i < NUM_AXES; i++) begin
      m_axis_tdata[2*NUM_AXES + 2 + i*VAL_BITS +: VAL_BITS] = out_pos_q[i];
    end
  end

  assign m_axis_tvalid = out_valid_q;

`ifndef SYNTHESIS
  // the last step of a move leaves nothing to do
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_done_q |-> !out_busy_q)
    else $error("move_done with busy_res set");

  // no step pulses once the step count is exhausted
  a_idle_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (steps_left_q == '0) && (in_type_q == REQ_TICK) |=> out_step_q == '0)
    else $error("step pulse while idle");

  // the step count never exceeds the longest delta
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_left_q <= longest_q)
    else $error("step count above longest delta");

  // a stalled item stays in the item register
  a_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(in_type_q))
    else $error("item dropped under stall");
`endif

endmodule

### test/step_motion_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the four-axis Bresenham stepper: predicts each result beat
// from the accepted input beats and mode writes, then compares it per field.
// Depends on fabs_pkg.
module step_motion_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,
  input  logic                                s_tvalid_i,
  input  logic                                s_tready_i,
  input  logic [fabs_pkg::IN_TDATA_BITS-1:0]  s_tdata_i,
  input  logic                                s_tuser_i,
  input  logic                                m_tvalid_i,
  input  logic                                m_tready_i,
  input  logic [fabs_pkg::OUT_TDATA_BITS-1:0] m_tdata_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  import fabs_pkg::*;

  localparam longint STEP_MAX = (longint'(1) << STEP_BITS) - 1;

  typedef struct packed {
    logic [NUM_AXES-1:0]               steps;
    logic [NUM_AXES-1:0]               dirs;
    logic                              done;
    logic                              busy;
    logic [NUM_AXES-1:0][VAL_BITS-1:0] pos;
  } motion_t;

  // predicted stepper state
  logic   abs_mode;
  longint axis_mag   [NUM_AXES];
  longint axis_err   [NUM_AXES];
  longint longest_mag;
  longint steps_remaining;
  logic [NUM_AXES-1:0] dir_bits;
  pos_t   axis_pos   [NUM_AXES];

  motion_t expected_motion_q[$];
  motion_t want_beat, got_beat;
  logic [NUM_AXES-1:0][VAL_BITS-1:0] in_values;
  int     fails = 0;
  int     result_beats = 0;
  int     ax;
  string  axis_letter[NUM_AXES] = '{"x", "y", "a", "z"};

  // advance the predicted state by one input beat and return its result
  function automatic motion_t predict_motion(input logic is_tick,
                                             input logic [NUM_AXES-1:0] given,
                                             input logic [NUM_AXES-1:0][VAL_BITS-1:0] vals);
    motion_t m;
    longint  d, mag, widest, p;
    m = '0;
    if (!is_tick) begin
      // latch new per-axis magnitudes, directions and the step count
      widest = 0;
      dir_bits = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        d = 0;
        if (given[i]) begin
          d = longint'($signed(vals[i]));
          if (abs_mode) d = d - longint'($signed(axis_pos[i]));
        end
        if (d > 0) dir_bits[i] = 1'b1;
        mag = (d < 0) ? -d : d;
        if (mag > STEP_MAX) mag = STEP_MAX;
        axis_mag[i] = mag;
        axis_err[i] = 0;
        if (mag > widest) widest = mag;
      end
      longest_mag = widest;
      steps_remaining = widest;
    end else if (steps_remaining != 0) begin
      // advance every error term, step the axes that cross half the longest delta
      for (int i = 0; i < NUM_AXES; i++) begin
        axis_err[i] = axis_err[i] + axis_mag[i];
        if (2 * axis_err[i] >= longest_mag) begin
          axis_err[i] = axis_err[i] - longest_mag;
          m.steps[i] = 1'b1;
          axis_pos[i] = dir_bits[i] ? axis_pos[i] + 1'b1 : axis_pos[i] - 1'b1;
        end
      end
      steps_remaining = steps_remaining - 1;
      if (steps_remaining == 0) m.done = 1'b1;
    end
    m.dirs = dir_bits;
    m.busy = (steps_remaining != 0);
    for (int i = 0; i < NUM_AXES; i++) begin
      p = longint'($signed(axis_pos[i]));
      m.pos[i] = p[VAL_BITS-1:0];
    end
    return m;
  endfunction

  task automatic flag_field(input string field, input longint unsigned want_v,
                            input longint unsigned got_v);
    if (want_v != got_v) begin
      fails++;
      if (fails <= 10)
        $display("result %0d: %s mismatch, expected %0h, got %0h",
                 result_beats, field, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_mode = 1'b1;
      for (int i = 0; i < NUM_AXES; i++) begin
        axis_mag[i] = 0;
        axis_err[i] = 0;
        axis_pos[i] = '0;
      end
      longest_mag = 0;
      steps_remaining = 0;
      dir_bits = '0;
      expected_motion_q.delete();
    end else begin
      // check the result beat against the oldest prediction first
      if (m_tvalid_i && m_tready_i) begin
        got_beat.steps = m_tdata_i[NUM_AXES-1:0];
        got_beat.dirs  = m_tdata_i[2*NUM_AXES-1:NUM_AXES];
        got_beat.done  = m_tdata_i[2*NUM_AXES];
        got_beat.busy  = m_tdata_i[2*NUM_AXES+1];
        for (ax = 0; ax < NUM_AXES; ax++)
          got_beat.pos[ax] = m_tdata_i[2*NUM_AXES+2+VAL_BITS*ax +: VAL_BITS];
        if (expected_motion_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("result %0d: unexpected beat %0h", result_beats, m_tdata_i);
        end else begin
          want_beat = expected_motion_q.pop_front();
          flag_field("steps", want_beat.steps, got_beat.steps);
          flag_field("dirs", want_beat.dirs, got_beat.dirs);
          flag_field("move_done", want_beat.done, got_beat.done);
          flag_field("busy", want_beat.busy, got_beat.busy);
          for (ax = 0; ax < NUM_AXES; ax++)
            flag_field($sformatf("pos_%s", axis_letter[ax]),
                       want_beat.pos[ax], got_beat.pos[ax]);
        end
        result_beats++;
      end
      if (cfg_we_i) abs_mode = cfg_wdata_i;
      // predict the input beat
      if (s_tvalid_i && s_tready_i) begin
        for (ax = 0; ax < NUM_AXES; ax++)
          in_values[ax] = s_tdata_i[NUM_AXES+VAL_BITS*ax +: VAL_BITS];
        expected_motion_q.push_back(predict_motion(s_tuser_i == REQ_TICK,
                                                   s_tdata_i[NUM_AXES-1:0], in_values));
      end
    end
    pending_o    <= expected_motion_q.size();
    fail_count_o <= fails;
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// Top of the stepper testbench: clock, reset, move and tick stimulus,
// random idling on both sides and the verdict. Depends on fabs_pkg,
// step_motion_checker and four_axis_bresenham_stepper.
module tb_top;
  import fabs_pkg::*;

  logic                      clk_i = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic                      cfg_wdata = 1'b0;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
  req_e                      s_tuser = REQ_TICK;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  int                        fail_count;
  int                        pending;

  logic calm = 1'b0;     // no idling while set
  int   beats_sent = 0;

  always #6 clk_i = ~clk_i;

  four_axis_bresenham_stepper DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  step_motion_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // mostly no gap or a short one, now and then a long one
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // present one beat after a random gap and hold it until accepted
  task automatic send_beat(input req_e kind, input logic [NUM_AXES-1:0] given,
                           input logic [VAL_BITS-1:0] vx, input logic [VAL_BITS-1:0] vy,
                           input logic [VAL_BITS-1:0] va, input logic [VAL_BITS-1:0] vz);
    int gap;
    logic [IN_TDATA_BITS-1:0] beat;
    gap = pick_idle();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    beat = '0;
    beat[NUM_AXES-1:0] = given;
    beat[NUM_AXES+0*VAL_BITS +: VAL_BITS] = vx;
    beat[NUM_AXES+1*VAL_BITS +: VAL_BITS] = vy;
    beat[NUM_AXES+2*VAL_BITS +: VAL_BITS] = va;
    beat[NUM_AXES+3*VAL_BITS +: VAL_BITS] = vz;
    s_tvalid <= 1'b1;
    s_tdata  <= beat;
    s_tuser  <= kind;
    do @(posedge clk_i); while (!s_tready);
    beats_sent++;
  endtask

  task automatic send_ticks(input int count);
    repeat (count)
      send_beat(REQ_TICK, NUM_AXES'($urandom_range(0, 15)), $urandom(), $urandom(),
                $urandom(), $urandom());
  endtask

  // drain all results, then write the mode register
  task automatic set_mode(input logic m);
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // result side: random stalls
  initial begin
    int idle;
    while (!rst_n) @(posedge clk_i);
    forever begin
      idle = pick_idle();
      if (idle > 0) begin
        m_tready <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  initial begin
    #15ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int phase_end, r, span;
    logic [NUM_AXES-1:0] given;
    logic [VAL_BITS-1:0] v [NUM_AXES];
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed: absolute mode out of reset
    send_ticks(1);
    send_beat(REQ_MOVE, 4'hf, 32'd3, -32'sd2, 32'd1, 32'd0);
    send_ticks(4);
    send_beat(REQ_MOVE, 4'h0, $urandom(), $urandom(), $urandom(), $urandom());
    send_ticks(1);
    // saturated magnitudes, then replace the move mid-way
    send_beat(REQ_MOVE, 4'h5, 32'h7fff_ffff, $urandom(), 32'h8000_0000, $urandom());
    send_ticks(2);
    send_beat(REQ_MOVE, 4'ha, $urandom(), 32'd2, $urandom(), -32'sd1);
    send_ticks(3);
    // relative mode
    set_mode(1'b0);
    send_beat(REQ_MOVE, 4'hf, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd0);
    send_ticks(1);
    send_beat(REQ_MOVE, 4'hf, 32'd1, -32'sd1, 32'd1, -32'sd1);
    send_ticks(2);
    send_beat(REQ_MOVE, 4'h3, 32'd0, 32'd0, $urandom(), $urandom());
    send_ticks(1);

    // random phases, alternating the mode
    for (int phase = 0; phase < 4; phase++) begin
      set_mode(phase[0] ? 1'b0 : 1'b1);
      phase_end = beats_sent + 432;
      while (beats_sent < phase_end) begin
        if ($urandom_range(0, 9) == 0) calm = ~calm;
        r = $urandom_range(0, 99);
        given = NUM_AXES'($urandom_range(0, 15));
        for (int i = 0; i < NUM_AXES; i++) v[i] = $urandom();
        if (r < 80) begin
          // small move, mostly run to completion, sometimes cut short
          span = $urandom_range(1, 15);
          for (int i = 0; i < NUM_AXES; i++)
            if (given[i]) v[i] = $urandom_range(0, 2 * span) - span;
          send_beat(REQ_MOVE, given, v[0], v[1], v[2], v[3]);
          if ($urandom_range(0, 99) < 85) send_ticks($urandom_range(2 * span, 2 * span + 4));
          else send_ticks($urandom_range(0, 6));
        end else if (r < 90) begin
          // huge move, a few steps, then replaced
          send_beat(REQ_MOVE, given, v[0], v[1], v[2], v[3]);
          send_ticks($urandom_range(0, 5));
        end else if (r < 95) begin
          send_beat(REQ_MOVE, 4'h0, v[0], v[1], v[2], v[3]);
        end else begin
          send_ticks($urandom_range(1, 4));
        end
      end
    end

    // drain and settle
    calm = 1'b0;
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
